// ----- rtl/mpdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdf_pkg
// Shared types and constants of the match pair duplicate filter.
// ----------------------------------------------------------------------------
package mpdf_pkg;

  localparam int MAX_PAIRS_DEF = 64;
  localparam int COORD_W       = 32;
  localparam int INDEX_W       = 6;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic               last_in;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] kept_first_x;
    logic [COORD_W-1:0] kept_first_y;
    logic [COORD_W-1:0] kept_second_x;
    logic [COORD_W-1:0] kept_second_y;
    logic [INDEX_W-1:0] kept_index;
    logic               last_out;
    logic               overflowed;
  } result_t;

  // One stored correspondence, as held in the pair memory.
  typedef struct packed {
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
  } pair_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/match_pair_dedup_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_pair_dedup_filter
// Loads point correspondences and emits the last occurrence of every point.
// ----------------------------------------------------------------------------
// Loading: a beat without last_in is taken and busy stays low.
// Filter pass: for each entry i, ST_RD_I and ST_LD_I fetch it, ST_SCAN compares it
// with each later entry in turn (stopping at the first match), and ST_EMIT emits a
// survivor; the pass is paced by the single read port of the pair memory. The
// receiver cannot stall. Reset (rst, synchronous) empties the list and clears the
// overflow flag; the pair memory is not cleared.
module match_pair_dedup_filter
  import mpdf_pkg::*;
#(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  // Pair memory: one write port, one synchronous read port.
  pair_t mem [MAX_PAIRS];
  pair_t rd_data;
  logic  rd_en;
  logic  [IDX_W-1:0] rd_addr;
  logic  wr_en;

  // Control and datapath registers.
  state_t state, state_next;
  logic [CNT_W-1:0] count;      // number of stored entries
  logic             overflow;   // an item of this list was dropped
  logic [IDX_W-1:0] i;          // entry under test
  logic [IDX_W-1:0] j;          // later entry being compared
  pair_t            cur;        // copy of entry i

  logic accept;
  logic room;
  logic [CNT_W-1:0] i_next_cnt;
  logic [CNT_W-1:0] j_next_cnt;
  logic match;

  assign accept     = start && !busy;
  assign room       = (count < CNT_W'(MAX_PAIRS));
  assign wr_en      = accept && room;
  assign i_next_cnt = CNT_W'(i) + CNT_W'(1);
  assign j_next_cnt = CNT_W'(j) + CNT_W'(1);

  // Bit-exact compare of either point; +0 and -0 differ, equal NaNs match.
  assign match = ((cur.fx == rd_data.fx) && (cur.fy == rd_data.fy)) ||
                 ((cur.sx == rd_data.sx) && (cur.sy == rd_data.sy));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= '{fx: item.first_x, fy: item.first_y,
                                 sx: item.second_x, sy: item.second_y};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && item.last_in) state_next = ST_RD_I;
      end
      ST_RD_I: state_next = ST_LD_I;
      ST_LD_I: begin
        // The final stored entry has no later entries and always survives.
        if (i_next_cnt == count) state_next = ST_EMIT;
        else                     state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (match)                    state_next = ST_RD_I;
        else if (j_next_cnt == count) state_next = ST_EMIT;
        else                          state_next = ST_SCAN;
      end
      ST_EMIT: begin
        if (i_next_cnt == count) state_next = ST_IDLE;
        else                     state_next = ST_RD_I;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory read control.
  always_comb begin
    busy    = (state != ST_IDLE);
    strobe  = (state == ST_EMIT);
    rd_en   = 1'b0;
    rd_addr = i;
    case (state)
      ST_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i;
      end
      ST_LD_I: begin
        rd_en   = 1'b1;
        rd_addr = i + IDX_W'(1);
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = j + IDX_W'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = i;
      end
    endcase
    result.kept_first_x  = cur.fx;
    result.kept_first_y  = cur.fy;
    result.kept_second_x = cur.sx;
    result.kept_second_y = cur.sy;
    result.kept_index    = INDEX_W'(i);
    result.last_out      = (i_next_cnt == count);
    result.overflowed    = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      i        <= '0;
      j        <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (room) count    <= count + CNT_W'(1);
            else      overflow <= 1'b1;
          end
          i <= '0;
        end
        ST_LD_I: begin
          cur <= rd_data;
          j   <= i + IDX_W'(1);
        end
        ST_SCAN: begin
          // A later duplicate drops entry i; move on to the next entry.
          if (match) i <= i + IDX_W'(1);
          else       j <= j + IDX_W'(1);
        end
        ST_EMIT: begin
          if (i_next_cnt == count) begin
            count    <= '0;
            overflow <= 1'b0;
            i        <= '0;
          end else begin
            i <= i + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every result beat belongs to a filter pass.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result beat outside a filter pass");

  // The final survivor ends the pass and frees the block.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_out |=> !busy) else $error("pass did not end on last_out");

  // A load beat without last_in leaves the block free.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.last_in |=> !busy) else $error("load beat blocked");

  // The entry count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PAIRS)) else $error("entry count over capacity");
`endif

endmodule

// ----- sim/match_pair_dedup_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_pair_dedup_filter_tb
// Self-checking bench for the keep-last duplicate filter. Lists of point
// correspondences are loaded beat by beat. Each list that closes with last_in
// is mirrored in a behavioral filter inside the bench. Every survivor beat
// from the block is compared field by field, in order, with the survivors
// that the bench has worked out.
// ----------------------------------------------------------------------------
module match_pair_dedup_filter_tb;
  import mpdf_pkg::*;

  localparam int DEPTH        = MAX_PAIRS_DEF;
  localparam int RANDOM_BEATS = 480;
  localparam int DRAIN_CYCLES = 300;
  localparam int TIMEOUT_NS   = 2_000_000;

  // Float bit patterns that break float equality. They must be compared raw.
  localparam logic [COORD_W-1:0] NEG_ZERO = 32'h8000_0000;
  localparam logic [COORD_W-1:0] QNAN     = 32'h7FC0_0000;
  localparam logic [COORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  match_pair_dedup_filter #(
    .MAX_PAIRS(DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .strobe(strobe),
    .result(result)
  );

  // Directed stimulus. A row either has its single survivor typed in, or it
  // leaves the expectation to the behavioral filter below.
  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } plan_row_t;

  plan_row_t plan[$];

  // Bench copy of the block state: the list loaded so far and the overflow
  // flag of that list.
  pair_t       held_pairs[DEPTH];
  int unsigned held_count;
  bit          held_overflow;

  result_t survivors_now[$];  // survivors of the pass closed by the last beat
  result_t kept_due[$];       // survivor beats still owed by the block

  // The driver states whether the beat it presents has a typed expectation.
  bit      beat_typed;
  result_t beat_want;

  int unsigned beats_taken;
  int          error_count;

  // Clock and run limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Behavioral filter. The beat is stored if there is room, or else the list
  // is marked as overflowed. A beat with last_in then runs the pass. An entry
  // survives only when no later entry repeats its first point or its second
  // point. The last stored entry always survives and carries last_out.
  task automatic load_and_filter(input item_t b);
    bit      keep[DEPTH];
    int      last_keep;
    result_t r;
    survivors_now.delete();
    if (held_count < DEPTH) begin
      held_pairs[held_count] = '{b.first_x, b.first_y, b.second_x, b.second_y};
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (b.last_in) begin
      last_keep = 0;
      for (int i = 0; i < held_count; i++) begin
        keep[i] = 1'b1;
        for (int j = i + 1; j < held_count; j++) begin
          if ((held_pairs[i].fx == held_pairs[j].fx && held_pairs[i].fy == held_pairs[j].fy) ||
              (held_pairs[i].sx == held_pairs[j].sx && held_pairs[i].sy == held_pairs[j].sy)) begin
            keep[i] = 1'b0;
          end
        end
        if (keep[i]) begin
          last_keep = i;
        end
      end
      for (int i = 0; i < held_count; i++) begin
        if (keep[i]) begin
          r.kept_first_x  = held_pairs[i].fx;
          r.kept_first_y  = held_pairs[i].fy;
          r.kept_second_x = held_pairs[i].sx;
          r.kept_second_y = held_pairs[i].sy;
          r.kept_index    = INDEX_W'(i);
          r.last_out      = (i == last_keep);
          r.overflowed    = held_overflow;
          survivors_now.insert(survivors_now.size(), r);
        end
      end
      // The list is consumed. The next beat starts a new one.
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  task automatic compare_kept(input result_t got, input result_t want);
    check_field("kept_first_x", want.kept_first_x, got.kept_first_x);
    check_field("kept_first_y", want.kept_first_y, got.kept_first_y);
    check_field("kept_second_x", want.kept_second_x, got.kept_second_x);
    check_field("kept_second_y", want.kept_second_y, got.kept_second_y);
    check_field("kept_index", COORD_W'(want.kept_index), COORD_W'(got.kept_index));
    check_field("last_out", COORD_W'(want.last_out), COORD_W'(got.last_out));
    check_field("overflowed", COORD_W'(want.overflowed), COORD_W'(got.overflowed));
  endtask

  // Monitor. It samples at the rising edge, before the block's registers
  // move. A survivor beat is checked before an input beat at the same edge is
  // predicted. This keeps the due queue in order, because a pass can only
  // emit after the beat that closes its list has been taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (kept_due.size() == 0) begin
          $error("survivor beat with none due: index %0d", result.kept_index);
          error_count++;
        end else begin
          compare_kept(result, kept_due.pop_front());
        end
      end
      if (start && !busy) begin
        load_and_filter(item);
        if (beat_typed) begin
          kept_due.insert(kept_due.size(), beat_want);
        end else begin
          foreach (survivors_now[k]) begin
            kept_due.insert(kept_due.size(), survivors_now[k]);
          end
        end
        beats_taken++;
      end
    end
  end

  // Driver. It is entered at a falling edge. It idles for the drawn gap, then
  // presents the beat and holds it until the monitor has seen it taken. With
  // no gap, start stays high from one beat to the next, so that start gets
  // one assignment per edge.
  task automatic send_beat(input item_t b, input bit typed, input result_t want,
                           input int gap);
    int unsigned goal;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= b;
    start      <= 1'b1;
    beat_typed = typed;
    beat_want  = want;
    goal       = beats_taken + 1;
    do @(negedge clk); while (beats_taken < goal);
  endtask

  task automatic add_row(input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                         input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                         input bit last, input bit typed, input result_t want);
    plan_row_t row;
    row.beat  = item_t'{fx, fy, sx, sy, last};
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endtask

  // Coordinates lean toward the patterns that float equality gets wrong, so
  // that random lists also meet signed zeros, NaNs and all ones.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return NEG_ZERO;
      2:       return QNAN;
      3:       return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // One random list. Points are drawn mostly from a small pool, so that whole
  // repeats, half repeats (x only or y only) and cross repeats between the first
  // and the second image are frequent. The rest are fresh random points. A list
  // with no idling keeps start high across every beat, the closing one included.
  task automatic send_random_list(input int len, input bit idle_free);
    logic [COORD_W-1:0] pool_x[4];
    logic [COORD_W-1:0] pool_y[4];
    int                 pool_n;
    int                 p;
    item_t              b;
    pool_n = $urandom_range(1, 4);
    for (int k = 0; k < pool_n; k++) begin
      pool_x[k] = pick_coord();
      pool_y[k] = pick_coord();
    end
    for (int k = 0; k < len; k++) begin
      p = $urandom_range(0, pool_n - 1);
      case ($urandom_range(0, 3))
        0, 1: begin
          b.first_x = pool_x[p];
          b.first_y = pool_y[p];
        end
        2: begin
          b.first_x = pool_x[p];
          b.first_y = pick_coord();
        end
        default: begin
          b.first_x = pick_coord();
          b.first_y = pick_coord();
        end
      endcase
      p = $urandom_range(0, pool_n - 1);
      case ($urandom_range(0, 3))
        0, 1: begin
          b.second_x = pool_x[p];
          b.second_y = pool_y[p];
        end
        2: begin
          b.second_x = pick_coord();
          b.second_y = pool_y[p];
        end
        default: begin
          b.second_x = pick_coord();
          b.second_y = pick_coord();
        end
      endcase
      b.last_in = (k == len - 1);
      send_beat(b, 1'b0, '0, idle_free ? 0 : $urandom_range(0, 10));
    end
  endtask

  initial begin
    int unsigned random_sent;
    int          list_no;
    int          len;

    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    beat_typed    = 1'b0;
    beat_want     = '0;
    beats_taken   = 0;
    error_count   = 0;
    held_count    = 0;
    held_overflow = 1'b0;

    // Single-entry lists straight after reset. The one entry comes back
    // unchanged at index 0 with last_out set.
    add_row('0, '0, '0, '0, 1'b1, 1'b1, result_t'{'0, '0, '0, '0, 6'd0, 1'b1, 1'b0});
    add_row(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1,
            result_t'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 6'd0, 1'b1, 1'b0});
    // A repeated first point drops the earlier entry.
    add_row(32'd1, 32'd2, 32'd3, 32'd4, 1'b0, 1'b0, '0);
    add_row(32'd1, 32'd2, 32'd5, 32'd6, 1'b1, 1'b0, '0);
    // +0 and -0 are different points, so both entries stay.
    add_row('0, '0, 32'd7, 32'd8, 1'b0, 1'b0, '0);
    add_row(NEG_ZERO, '0, 32'd7, 32'd9, 1'b1, 1'b0, '0);
    // Equal NaN patterns are the same point.
    add_row(QNAN, QNAN, 32'd1, 32'd1, 1'b0, 1'b0, '0);
    add_row(QNAN, QNAN, 32'd2, 32'd2, 1'b1, 1'b0, '0);
    // A repeated second point drops the first entry. The other two stay.
    add_row(32'd10, 32'd11, 32'd20, 32'd21, 1'b0, 1'b0, '0);
    add_row(32'd12, 32'd13, 32'd20, 32'd21, 1'b0, 1'b0, '0);
    add_row(32'd14, 32'd15, 32'd22, 32'd23, 1'b1, 1'b0, '0);
    // Points that share only x, or that swap x and y, are not repeats.
    add_row(32'd30, 32'd31, 32'd40, 32'd41, 1'b0, 1'b0, '0);
    add_row(32'd30, 32'd99, 32'd41, 32'd40, 1'b1, 1'b0, '0);
    // A first point that shows up as a later second point is not a repeat.
    add_row(32'd50, 32'd51, 32'd60, 32'd61, 1'b0, 1'b0, '0);
    add_row(32'd60, 32'd61, 32'd50, 32'd51, 1'b1, 1'b0, '0);
    // A point seen three times keeps only its last occurrence.
    add_row(32'd70, 32'd71, 32'd72, 32'd73, 1'b0, 1'b0, '0);
    add_row(32'd70, 32'd71, 32'd74, 32'd75, 1'b0, 1'b0, '0);
    add_row(32'd80, 32'd81, 32'd82, 32'd83, 1'b0, 1'b0, '0);
    add_row(32'd70, 32'd71, 32'd84, 32'd85, 1'b1, 1'b0, '0);
    // Opposite extremes in each coordinate. Both entries survive.
    add_row(ALL_ONES, '0, ALL_ONES, '0, 1'b0, 1'b0, '0);
    add_row('0, ALL_ONES, '0, ALL_ONES, 1'b1, 1'b0, '0);

    // Reset is released at a falling edge. The first beat then goes out at a
    // falling edge.
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[r]) begin
      send_beat(plan[r].beat, plan[r].typed, plan[r].want, $urandom_range(0, 10));
    end

    // Random lists. Most are short. Every eighth list is mid-sized. A few
    // fill the table exactly, or run past it so that overflow is flagged and
    // a closing beat past capacity still starts the pass.
    random_sent = 0;
    list_no     = 0;
    while (random_sent < RANDOM_BEATS) begin
      if (list_no % 16 == 5) begin
        len = DEPTH + $urandom_range(1, 3);
      end else if (list_no % 16 == 13) begin
        len = DEPTH;
      end else if (list_no % 8 == 2) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(1, 8);
      end
      send_random_list(len, $urandom_range(0, 2) == 0);
      random_sent += len;
      list_no++;
    end

    // Every list closed with last_in. Wait for the owed survivors. Then watch
    // a while longer for stray strobes.
    start <= 1'b0;
    while (kept_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- match_pair_dedup_filter.f -----
rtl/mpdf_pkg.sv
rtl/match_pair_dedup_filter.sv
sim/match_pair_dedup_filter_tb.sv
